FILE: sv/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types, fixed constants and the quarter-wave sine helper.
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int unsigned CFG_W   = 32;
    localparam int unsigned SINE_W  = 16;
    localparam int unsigned TURN_W  = 32;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_MAX   = 64'd32767;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // sin of a quarter-turn fraction r (Q30, 0..2^30), Q1.15, Taylor to x^9
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        sum  = x;
        term = ((x * x2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        v    = (sum * SINE_MAX + (Q30_ONE >> 1)) >> 30;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

FILE: sv/sam_queue.sv
// ----------------------------------------------------------------------------
// sam_queue
// Small first-word-fall-through queue with occupancy count.
// ----------------------------------------------------------------------------
module sam_queue
    import sam_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output t_qstat                     o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];
    assign o_count      = r_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: sv/sam_front.sv
// ----------------------------------------------------------------------------
// sam_front
// Holds the phase step, runs the carrier phase accumulator and forms the
// sine table index for each accepted item.
// ----------------------------------------------------------------------------
module sam_front
    import sam_pkg::*;
#(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_W-1:0]                    i_cfg_wdata,
    input  logic                                i_accept,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic signed [SAMPLE_BITS-1:0]       i_envelope,
    input  logic                                i_first,
    output logic [2*SAMPLE_BITS+$clog2(SINE_TABLE_DEPTH)-1:0] o_item
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int MUL_W = PHASE_BITS + IDX_W + 1;

    logic [CFG_W-1:0]      r_step;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] w_p;
    logic [MUL_W-1:0]      w_scaled;
    logic [IDX_W-1:0]      w_idx;

    assign w_p      = i_first ? '0 : r_phase;
    assign w_scaled = MUL_W'(w_p) * MUL_W'(SINE_TABLE_DEPTH);
    assign w_idx    = w_scaled[PHASE_BITS +: IDX_W];
    assign o_item   = {i_sample_in, i_envelope, w_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase <= w_p + PHASE_BITS'(r_step);
            end
        end
    end

endmodule

FILE: sv/sam_back.sv
// ----------------------------------------------------------------------------
// sam_back
// Sine lookup, sample x envelope x sine product, rounding and saturation,
// and the result queue.
// ----------------------------------------------------------------------------
module sam_back
    import sam_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16,
    parameter int OUT_DEPTH        = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [2*SAMPLE_BITS+$clog2(SINE_TABLE_DEPTH)-1:0] i_item,
    input  t_qstat                              i_mid_stat,
    output logic                                o_mid_pop,
    input  logic                                i_pop,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output t_qstat                              o_out_stat
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int P1_W  = 2 * SAMPLE_BITS;
    localparam int PW    = P1_W + SINE_W;
    localparam int SH    = SAMPLE_BITS - 1 + 15;
    localparam int CW    = $clog2(OUT_DEPTH + 1);
    localparam logic [PW:0] RND_HALF = (PW + 1)'(1) << (SH - 1);
    localparam logic signed [PW:0] SAT_MAX = (PW + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PW:0] SAT_MIN = -SAT_MAX - (PW + 1)'(1);

    typedef logic signed [SINE_W-1:0] t_rom [SINE_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] t;
        logic [63:0] r;
        logic [SINE_W-1:0] s;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            t = (64'(k) << TURN_W) / SINE_TABLE_DEPTH;
            r = t & (Q30_ONE - 64'd1);
            if (t[30]) begin
                r = Q30_ONE - r;
            end
            s = quarter_sine(r);
            rom[k] = t[31] ? -$signed(s) : $signed(s);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic signed [SAMPLE_BITS-1:0] w_smp;
    logic signed [SAMPLE_BITS-1:0] w_env;
    logic [IDX_W-1:0]              w_idx;
    logic                          r_v1;
    logic                          r_v2;
    logic signed [SINE_W-1:0]      r_sine;
    logic signed [P1_W-1:0]        r_p1;
    logic signed [PW-1:0]          r_p2;
    logic signed [PW:0]            w_rnd;
    logic signed [PW:0]            w_q;
    logic signed [SAMPLE_BITS-1:0] w_res;
    logic [CW-1:0]                 w_out_count;
    logic [CW:0]                   w_load;

    assign {w_smp, w_env, w_idx} = i_item;

    assign w_load    = (CW + 1)'(w_out_count) + (CW + 1)'(r_v1) + (CW + 1)'(r_v2);
    assign o_mid_pop = !i_mid_stat.empty && (w_load < (CW + 1)'(OUT_DEPTH));

    assign w_rnd = $signed({r_p2[PW-1], r_p2}) + $signed(RND_HALF);
    assign w_q   = w_rnd >>> SH;

    always_comb begin
        if (w_q > SAT_MAX) begin
            w_res = SAMPLE_BITS'(SAT_MAX);
        end else if (w_q < SAT_MIN) begin
            w_res = SAMPLE_BITS'(SAT_MIN);
        end else begin
            w_res = SAMPLE_BITS'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_mid_pop;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_sine <= SINE_ROM[w_idx];
            r_p1   <= w_smp * w_env;
        end
        if (r_v1) begin
            r_p2 <= r_p1 * r_sine;
        end
    end

    sam_queue #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v2),
        .i_data  (w_res),
        .i_pop   (i_pop),
        .o_data  (o_sample_out),
        .o_count (w_out_count),
        .o_stat  (o_out_stat)
    );

endmodule

FILE: sv/sine_am_modulator.sv
// ----------------------------------------------------------------------------
// sine_am_modulator
// Multiplies each audio sample by its envelope value and by a table sine
// carrier driven from a phase accumulator; result rounded and saturated.
// ----------------------------------------------------------------------------
// Items are taken in one per cycle while the middle queue is not full, and
// results leave one per cycle while results wait and pop is high. The front
// stage owns the phase accumulator and table index and feeds a two-entry
// queue. The back stage reads the sine table and multiplies sample x envelope
// in one registered stage, multiplies by the sine in a second, and rounds into
// a four-entry result queue. It pops the middle queue only when the result
// queue has room for everything in flight. An item with first set uses phase
// zero. phase_step is written through i_cfg_we / i_cfg_wdata and is first
// added to the phase when the next item is accepted.
module sine_am_modulator
    import sam_pkg::*;
#(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [SAMPLE_BITS-1:0] i_envelope,
    input  logic                          i_first,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int ITEM_W    = 2 * SAMPLE_BITS + $clog2(SINE_TABLE_DEPTH);
    localparam int MID_DEPTH = 2;

    logic [ITEM_W-1:0]               w_front_item;
    logic [ITEM_W-1:0]               w_mid_item;
    logic [$clog2(MID_DEPTH+1)-1:0]  w_mid_count;
    t_qstat                          w_mid_stat;
    t_qstat                          w_out_stat;
    logic                            w_accept;
    logic                            w_mid_pop;

    assign full     = w_mid_stat.full;
    assign empty    = w_out_stat.empty;
    assign w_accept = push && !w_mid_stat.full;

    sam_front #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_sample_in (i_sample_in),
        .i_envelope  (i_envelope),
        .i_first     (i_first),
        .o_item      (w_front_item)
    );

    sam_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_item),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_item),
        .o_count (w_mid_count),
        .o_stat  (w_mid_stat)
    );

    sam_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .OUT_DEPTH        (4)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_mid_item),
        .i_mid_stat   (w_mid_stat),
        .o_mid_pop    (w_mid_pop),
        .i_pop        (pop),
        .o_sample_out (o_sample_out),
        .o_out_stat   (w_out_stat)
    );

endmodule

FILE: sv/sam_checker.sv
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks for sine_am_modulator, attached by bind.
// ----------------------------------------------------------------------------
module sam_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_push,
    input logic                   i_full,
    input logic                   i_pop,
    input logic                   i_empty,
    input logic [SAMPLE_BITS-1:0] i_sample_out
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("queues not cleared by reset");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_full) |-> $past(i_push))
        else $error("full rose without an accepted item");

    a_min_latency: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |=> i_empty)
        else $error("result appeared too early after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_sample_out))
        else $error("waiting item changed or vanished");

endmodule

bind sine_am_modulator sam_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sam_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_push       (push),
    .i_full       (full),
    .i_pop        (pop),
    .i_empty      (empty),
    .i_sample_out (o_sample_out)
);
